// File: design/tlca_pkg.sv
package tlca_pkg;

    localparam int unsigned NodeBits = 10;
    localparam int unsigned NodeCount = 1 << NodeBits;
    localparam int unsigned DistBits = 32;
    localparam int unsigned WeightFieldBits = 16;

    typedef enum logic [1:0] {
        ACT_ROOT   = 2'd0,
        ACT_ATTACH = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]                 action;
        logic [NodeBits-1:0]        node_a;
        logic [NodeBits-1:0]        node_b;
        logic [WeightFieldBits-1:0] edge_weight;
    } t_request;

    typedef struct packed {
        logic [NodeBits-1:0] common_ancestor;
        logic [DistBits-1:0] path_distance;
    } t_result;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RD_DEPTH,
        OP_ROOT,
        OP_ATT_WR0,
        OP_ATT_RD,
        OP_ATT_WR,
        OP_Q_ORDER,
        OP_Q_RD,
        OP_Q_LIFT,
        OP_Q_CLIMB,
        OP_Q_FIN_RD,
        OP_Q_FIN
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [4:0]  level;
    } t_cmd;

    typedef struct packed {
        logic       same;
        logic       lift_bit;
        logic       climb_ok;
        logic       fill_ok;
    } t_status;

endpackage

// File: design/tlca_datapath.sv
module tlca_datapath #(
    parameter int unsigned LIFT_LEVELS = 10,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic               i_clk,
    input  tlca_pkg::t_request i_req,
    input  tlca_pkg::t_cmd     i_cmd,
    output tlca_pkg::t_status  o_status,
    output tlca_pkg::t_result  o_result
);
    localparam int unsigned NB = tlca_pkg::NodeBits;
    localparam int unsigned LB = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int unsigned DB = LIFT_LEVELS + 1;
    localparam int unsigned FB = tlca_pkg::NodeBits;
    localparam int unsigned XB = tlca_pkg::DistBits;
    localparam int unsigned TD = tlca_pkg::NodeCount * LIFT_LEVELS;
    localparam int unsigned IB = $clog2(TD);
    localparam logic [DB-1:0] MaxDepth = DB'((1 << LIFT_LEVELS) - 1);

    logic [DB-1:0] depth_mem [tlca_pkg::NodeCount];
    logic [NB-1:0] anc_mem   [TD];
    logic [XB-1:0] dist_mem  [TD];

    logic [NB-1:0] r_a, r_b, r_pa, r_pb;
    logic [XB-1:0] r_w, r_sum, r_da, r_db, r_dla;
    logic [DB-1:0] r_dep_a, r_dep_b, r_gap;

    logic [LB-1:0] lvl;
    logic [NB-1:0] in_a, in_b;
    logic [DB-1:0] dp_next;

    assign lvl  = i_cmd.level[LB-1:0];
    assign in_a = i_req.node_a;
    assign in_b = i_req.node_b;
    assign dp_next = (r_dep_b >= MaxDepth) ? MaxDepth : r_dep_b + DB'(1);

    function automatic logic [IB-1:0] idx(input logic [LB-1:0] t, input logic [NB-1:0] n);
        return IB'({t, n});
    endfunction

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            tlca_pkg::OP_LOAD: begin
                r_a   <= in_a;
                r_b   <= in_b;
                r_w   <= XB'(i_req.edge_weight[WEIGHT_BITS > 16 ? 15 : WEIGHT_BITS-1:0]);
                r_sum <= '0;
            end
            tlca_pkg::OP_RD_DEPTH: begin
                r_dep_a <= depth_mem[r_a];
                r_dep_b <= depth_mem[r_b];
            end
            tlca_pkg::OP_ROOT: depth_mem[r_a] <= '0;
            tlca_pkg::OP_ATT_WR0: begin
                depth_mem[r_a] <= dp_next;
                r_dep_a <= dp_next;
                anc_mem[idx('0, r_a)]  <= r_b;
                dist_mem[idx('0, r_a)] <= r_w;
                r_pa  <= r_b;
                r_dla <= r_w;
            end
            tlca_pkg::OP_ATT_RD: begin
                r_pb <= anc_mem[idx(lvl - LB'(1), r_pa)];
                r_db <= dist_mem[idx(lvl - LB'(1), r_pa)];
            end
            tlca_pkg::OP_ATT_WR: begin
                anc_mem[idx(lvl, r_a)]  <= r_pb;
                dist_mem[idx(lvl, r_a)] <= r_dla + r_db;
                r_pa  <= r_pb;
                r_dla <= r_dla + r_db;
            end
            tlca_pkg::OP_Q_ORDER: begin
                if (r_dep_a < r_dep_b) begin
                    r_a <= r_b; r_b <= r_a;
                    r_dep_a <= r_dep_b; r_dep_b <= r_dep_a;
                    r_gap <= r_dep_b - r_dep_a;
                end else begin
                    r_gap <= r_dep_a - r_dep_b;
                end
            end
            tlca_pkg::OP_Q_RD: begin
                r_pa <= anc_mem[idx(lvl, r_a)];
                r_da <= dist_mem[idx(lvl, r_a)];
                r_pb <= anc_mem[idx(lvl, r_b)];
                r_db <= dist_mem[idx(lvl, r_b)];
            end
            tlca_pkg::OP_Q_LIFT: begin
                r_a   <= r_pa;
                r_sum <= r_sum + r_da;
            end
            tlca_pkg::OP_Q_CLIMB: begin
                r_a     <= r_pa;
                r_b     <= r_pb;
                r_sum   <= r_sum + r_da + r_db;
                r_dep_a <= r_dep_a - (DB'(1) << lvl);
            end
            tlca_pkg::OP_Q_FIN_RD: begin
                r_pa <= anc_mem[idx('0, r_a)];
                r_da <= dist_mem[idx('0, r_a)];
                r_db <= dist_mem[idx('0, r_b)];
            end
            tlca_pkg::OP_Q_FIN: begin
                r_a   <= r_pa;
                r_sum <= r_sum + r_da + r_db;
            end
            default: ;
        endcase
    end

    assign o_status.same     = (r_a == r_b);
    assign o_status.lift_bit = r_gap[lvl];
    assign o_status.climb_ok = (r_dep_a > (DB'(1) << lvl)) && (r_pa != r_pb);
    assign o_status.fill_ok  = ((DB'(1) << lvl) <= r_dep_a);
    assign o_result.common_ancestor = FB'(r_a);
    assign o_result.path_distance   = r_sum;
endmodule

// File: design/tlca_ctrl.sv
module tlca_ctrl #(
    parameter int unsigned LIFT_LEVELS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    output logic              o_stall,
    input  tlca_pkg::t_status i_status,
    output tlca_pkg::t_cmd    o_cmd,
    output logic              o_valid,
    input  logic              i_stall
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEPTH, S_DISPATCH, S_ATT0, S_ATT_RD, S_ATT_WR,
        S_Q_ORDER, S_LIFT_RD, S_LIFT, S_SAME, S_CL_RD, S_CLIMB, S_FIN_RD, S_FIN, S_OUT
    } t_state;

    t_state     r_state;
    logic [4:0] r_lvl;
    logic [1:0] r_act;
    logic       r_valid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_cmd.level = r_lvl;

    always_comb begin
        unique case (r_state)
            S_IDLE:    o_cmd.op = (i_valid) ? tlca_pkg::OP_LOAD : tlca_pkg::OP_IDLE;
            S_DEPTH:   o_cmd.op = tlca_pkg::OP_RD_DEPTH;
            S_DISPATCH: o_cmd.op = (r_act == tlca_pkg::ACT_ROOT) ? tlca_pkg::OP_ROOT
                                   : tlca_pkg::OP_IDLE;
            S_ATT0:    o_cmd.op = tlca_pkg::OP_ATT_WR0;
            S_ATT_RD:  o_cmd.op = tlca_pkg::OP_ATT_RD;
            S_ATT_WR:  o_cmd.op = tlca_pkg::OP_ATT_WR;
            S_Q_ORDER: o_cmd.op = tlca_pkg::OP_Q_ORDER;
            S_LIFT_RD: o_cmd.op = tlca_pkg::OP_Q_RD;
            S_LIFT:    o_cmd.op = i_status.lift_bit ? tlca_pkg::OP_Q_LIFT : tlca_pkg::OP_IDLE;
            // depth of the lifted node bounds the joint climb
            S_SAME:    o_cmd.op = tlca_pkg::OP_RD_DEPTH;
            S_CL_RD:   o_cmd.op = tlca_pkg::OP_Q_RD;
            S_CLIMB:   o_cmd.op = i_status.climb_ok ? tlca_pkg::OP_Q_CLIMB : tlca_pkg::OP_IDLE;
            S_FIN_RD:  o_cmd.op = tlca_pkg::OP_Q_FIN_RD;
            S_FIN:     o_cmd.op = tlca_pkg::OP_Q_FIN;
            default:   o_cmd.op = tlca_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_lvl   <= '0;
            r_act   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_act   <= i_action;
                    r_state <= S_DEPTH;
                end
                S_DEPTH: r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    priority case (r_act)
                        tlca_pkg::ACT_ATTACH: r_state <= S_ATT0;
                        tlca_pkg::ACT_QUERY: r_state <= S_Q_ORDER;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_ATT0: begin
                    r_lvl   <= 5'd1;
                    r_state <= S_ATT_RD;
                end
                S_ATT_RD: begin
                    if (32'(r_lvl) >= LIFT_LEVELS || !i_status.fill_ok) r_state <= S_IDLE;
                    else r_state <= S_ATT_WR;
                end
                S_ATT_WR: begin
                    r_lvl   <= r_lvl + 5'd1;
                    r_state <= S_ATT_RD;
                end
                S_Q_ORDER: begin
                    r_lvl   <= 5'(LIFT_LEVELS - 1);
                    r_state <= S_LIFT_RD;
                end
                S_LIFT_RD: r_state <= S_LIFT;
                S_LIFT: begin
                    if (r_lvl == 5'd0) r_state <= S_SAME;
                    else begin
                        r_lvl   <= r_lvl - 5'd1;
                        r_state <= S_LIFT_RD;
                    end
                end
                S_SAME: begin
                    r_lvl <= 5'(LIFT_LEVELS - 1);
                    if (i_status.same) begin
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else r_state <= S_CL_RD;
                end
                S_CL_RD: r_state <= S_CLIMB;
                S_CLIMB: begin
                    if (r_lvl == 5'd0) r_state <= S_FIN_RD;
                    else begin
                        r_lvl   <= r_lvl - 5'd1;
                        r_state <= S_CL_RD;
                    end
                end
                S_FIN_RD: r_state <= S_FIN;
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/tree_lca_binary_lifting.sv
// Binary-lifting lowest common ancestor engine over a weighted tree of NodeCount nodes.
// One request at a time: the input stalls from acceptance until the request is finished
// and its result, if any, has been taken. An attach makes one dependent table read per
// filled lifting level, and a query one per lifting level in each climb, skipping the
// joint climb when one node is an ancestor of the other.
// Nodes must arrive parent before child.
module tree_lca_binary_lifting #(
    parameter int unsigned LIFT_LEVELS = 10,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tlca_pkg::t_request i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output tlca_pkg::t_result  o_data
);
    tlca_pkg::t_cmd    cmd;
    tlca_pkg::t_status status;

    tlca_ctrl #(.LIFT_LEVELS(LIFT_LEVELS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_action(i_data.action), .o_stall,
        .i_status(status), .o_cmd(cmd), .o_valid, .i_stall
    );

    tlca_datapath #(
        .LIFT_LEVELS(LIFT_LEVELS), .WEIGHT_BITS(WEIGHT_BITS)
    ) u_dp (
        .i_clk, .i_req(i_data), .i_cmd(cmd), .o_status(status), .o_result(o_data)
    );
endmodule

// File: design/tlca_checker.sv
module tlca_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input tlca_pkg::t_result o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("request taken while result pending");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("no busy after request");
endmodule

bind tree_lca_binary_lifting tlca_checker u_chk (.*);

// File: tb/sv/tb_tree_lca_binary_lifting.sv
module tb_tree_lca_binary_lifting;

    localparam int unsigned NODES = 1024;
    localparam int unsigned LEVELS = 10;
    localparam int unsigned DEPTH_CAP = (1 << LEVELS) - 1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    tlca_pkg::t_request i_data;
    logic               o_valid;
    logic               i_stall;
    tlca_pkg::t_result  o_data;

    tree_lca_binary_lifting dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // tree model
    logic [9:0]  depth_of [NODES];
    logic [9:0]  lift_anc [LEVELS][NODES];
    logic [31:0] lift_dist [LEVELS][NODES];
    bit          linked [NODES];
    int          tree_of [NODES];

    tlca_pkg::t_request pending_requests[$];
    tlca_pkg::t_result  awaited_results[$];
    int       mismatch_count = 0;
    int       sender_idle_pct = 11;
    int       receiver_idle_pct = 54;
    int       hold_cycles = 0;
    bit       req_taken = 0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic void hang_node(input int x, input int parent, input logic [15:0] w);
        int d;
        int mid;
        d = depth_of[parent];
        d = (d >= DEPTH_CAP) ? DEPTH_CAP : d + 1;
        depth_of[x] = d;
        lift_anc[0][x] = parent;
        lift_dist[0][x] = w;
        for (int t = 1; t < LEVELS && (1 << t) <= d; t++) begin
            mid = lift_anc[t-1][x];
            lift_anc[t][x] = lift_anc[t-1][mid];
            lift_dist[t][x] = lift_dist[t-1][x] + lift_dist[t-1][mid];
        end
    endfunction

    function automatic tlca_pkg::t_result lca_of(input int a, input int b);
        tlca_pkg::t_result r;
        logic [31:0] sum;
        int gap;
        int s;
        int pa;
        int pb;
        sum = 0;
        if (depth_of[a] < depth_of[b]) begin
            s = a;
            a = b;
            b = s;
        end
        gap = depth_of[a] - depth_of[b];
        for (int t = LEVELS - 1; t >= 0; t--) begin
            if (gap & (1 << t)) begin
                sum += lift_dist[t][a];
                a = lift_anc[t][a];
            end
        end
        if (a == b) begin
            r.common_ancestor = a;
            r.path_distance = sum;
            return r;
        end
        gap = depth_of[a];
        for (int t = LEVELS - 1; t >= 0; t--) begin
            if (gap <= (1 << t)) continue;
            pa = lift_anc[t][a];
            pb = lift_anc[t][b];
            if (pa == pb) continue;
            sum += lift_dist[t][a] + lift_dist[t][b];
            a = pa;
            b = pb;
            gap -= 1 << t;
        end
        sum += lift_dist[0][a] + lift_dist[0][b];
        r.common_ancestor = lift_anc[0][a];
        r.path_distance = sum;
        return r;
    endfunction

    function automatic tlca_pkg::t_request make_request(input tlca_pkg::t_action act,
                                                        input int a, input int b,
                                                        input int w);
        tlca_pkg::t_request q;
        q.action = act;
        q.node_a = a;
        q.node_b = b;
        q.edge_weight = w;
        return q;
    endfunction

    // tracks tree membership so only well-formed queries are generated
    task automatic push_root(input int a);
        pending_requests.push_back(make_request(tlca_pkg::ACT_ROOT, a,
                                                $urandom_range(0, 1023), $urandom));
        linked[a] = 1;
        tree_of[a] = a;
    endtask

    task automatic push_attach(input int a, input int p, input int w);
        pending_requests.push_back(make_request(tlca_pkg::ACT_ATTACH, a, p, w));
        linked[a] = 1;
        tree_of[a] = tree_of[p];
    endtask

    function automatic int pick_linked();
        int n;
        do n = $urandom_range(0, NODES - 1); while (!linked[n]);
        return n;
    endfunction

    function automatic int pick_fresh();
        int n;
        do n = $urandom_range(0, NODES - 1); while (linked[n]);
        return n;
    endfunction

    task automatic push_query(input int a, input int b);
        pending_requests.push_back(make_request(tlca_pkg::ACT_QUERY, a, b, $urandom));
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_data <= pending_requests.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
                i_data <= $urandom;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // monitor: accepted requests update the model, results are checked
    always @(posedge i_clk) begin
        tlca_pkg::t_result want;
        req_taken = i_rst_n && i_valid && !o_stall;
        if (req_taken) begin
            case (tlca_pkg::t_action'(i_data.action))
                tlca_pkg::ACT_ROOT: depth_of[i_data.node_a] = 0;
                tlca_pkg::ACT_ATTACH:
                    hang_node(i_data.node_a, i_data.node_b, i_data.edge_weight);
                tlca_pkg::ACT_QUERY:
                    awaited_results.push_back(lca_of(i_data.node_a, i_data.node_b));
                default: ;
            endcase
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", o_data.common_ancestor, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_data.common_ancestor !== want.common_ancestor)
                    report_mismatch("common_ancestor", o_data.common_ancestor,
                                    want.common_ancestor);
                if (o_data.path_distance !== want.path_distance)
                    report_mismatch("path_distance", o_data.path_distance,
                                    want.path_distance);
            end
        end
    end

    task automatic drain();
        while (pending_requests.size() > 0 || i_valid || awaited_results.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        int r;
        int a;
        int b;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                pending_requests.push_back(make_request(tlca_pkg::ACT_NONE, $urandom,
                                                        $urandom, $urandom));
                k--;
            end else if (r < 45) begin
                a = pick_fresh();
                b = pick_linked();
                if ($urandom_range(0, 3) == 0)
                    push_attach(a, b, $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 9));
                else
                    push_attach(a, b, $urandom);
            end else begin
                a = pick_linked();
                do b = pick_linked(); while (tree_of[b] != tree_of[a]);
                push_query(a, b);
            end
        end
    endtask

    initial begin
        int chain;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        foreach (linked[n]) linked[n] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: roots, deep chain, extreme weights, self query, unused action
        push_root(0);
        push_root(1023);
        chain = 0;
        for (int n = 1; n < 12; n++) begin
            push_attach(n, chain, (n % 2) ? 16'hFFFF : 16'h0000);
            chain = n;
        end
        push_attach(1022, 1023, 16'hFFFF);
        push_attach(512, 5, 16'h5555);
        push_attach(513, 5, 16'hAAAA);
        pending_requests.push_back(make_request(tlca_pkg::ACT_NONE, 10'h3FF, 10'h3FF,
                                                16'hFFFF));
        push_query(11, 0);
        push_query(0, 11);
        push_query(512, 513);
        push_query(11, 11);
        push_query(1022, 1023);
        push_query(513, 9);
        push_query(1023, 1022);
        drain();

        random_phase(180);
        // long receiver hold-off fills the block and stalls its input
        hold_cycles = 400;
        drain();
        sender_idle_pct = 54;
        receiver_idle_pct = 11;
        random_phase(180);
        drain();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_phase(170);
        drain();
        repeat (100) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("status: fail");
        $finish;
    end

endmodule
